// ===== rtl/lba_pkg.sv =====
// lba_pkg: shared types and constants of the LED breathe/blink animator
// used by lba_ctrl, lba_datapath and the top level; depends on nothing
package lba_pkg;

    // fixed field widths
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int GRAD_W    = 12;
    localparam int BTIMES_W  = 8;
    localparam int BLEFT_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int IN_DAT_W  = 8;
    localparam int OUT_USR_W = 2;

    // animation modes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_STEADY = 2'd1;
    localparam logic [1:0] MODE_GRAD   = 2'd2;
    localparam logic [1:0] MODE_BLINK  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BTIMES  = 3'd4;

    // color channel order through the blend unit
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [CHAN_W-1:0] MIX_MAX = 8'd255;

    // commands from controller to datapath
    typedef struct packed {
        logic       take_item;
        logic       simple_step;
        logic       pos_inc;
        logic       mod_start;
        logic       mod_store;
        logic       mix_start;
        logic       mix_store;
        logic       blend_mul;
        logic       blend_div;
        logic       out_load;
        logic [1:0] ch;
    } lba_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic grad_tick;
        logic tp1_lt_p;
        logic div_done;
        logic out_free;
    } lba_stat_t;

endpackage

// ===== rtl/lba_div.sv =====
// lba_div: restoring divider, one quotient bit per cycle
// gives quotient and remainder; no package dependency
module lba_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] rem_next;
    logic [DVD_W-1:0] quo_next;

    // one trial subtraction per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/lba_datapath.sv =====
// lba_datapath: configuration registers, animation state, divider, blend unit
// and result register; depends on lba_pkg and lba_div
module lba_datapath
    import lba_pkg::*;
#(
    parameter int TICK_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lba_cmd_t             cmd,
    output lba_stat_t            stat,
    input  logic                 in_restart,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [COLOR_W-1:0]   m_axis_tdata,
    output logic [OUT_USR_W-1:0] m_axis_tuser
);
    localparam int DIV_W = TICK_BITS + 8;

    // configuration
    logic [1:0]          mode_reg;
    logic [COLOR_W-1:0]  color_a_reg;
    logic [COLOR_W-1:0]  color_b_reg;
    logic [TICK_BITS-1:0] period_reg;
    logic [BTIMES_W-1:0] btimes_reg;

    // animation state
    logic [TICK_BITS-1:0] tick_position_reg, tick_position_next;
    logic [BLEFT_W-1:0]   blink_left_reg, blink_left_next;
    logic [COLOR_W-1:0]   shown_color_reg, shown_color_next;
    logic                 shown_lit_reg, shown_lit_next;
    logic                 anim_active_reg, anim_active_next;

    // work registers
    logic                 restart_reg;
    logic [CHAN_W-1:0]    mix_reg;
    logic [15:0]          blend_reg;

    // result register
    logic                 out_valid_reg;
    logic [COLOR_W-1:0]   out_data_reg;
    logic [OUT_USR_W-1:0] out_user_reg;

    logic [TICK_BITS:0]   tp1;
    logic [TICK_BITS-1:0] half;
    logic [TICK_BITS-1:0] xdist;
    logic [DIV_W-1:0]     mix_dividend;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [TICK_BITS-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [TICK_BITS-1:0] div_rem;
    logic [BLEFT_W-1:0]   bl_dec;

    logic [CHAN_W-1:0]    ch_a;
    logic [CHAN_W-1:0]    ch_b;
    logic signed [8:0]    ch_diff;
    logic signed [17:0]   ch_prod;
    logic signed [17:0]   ch_base;
    logic signed [17:0]   ch_sum;
    logic [23:0]          recip;
    logic [CHAN_W-1:0]    q_est;
    logic [15:0]          q_back;
    logic [15:0]          q_rem;
    logic [CHAN_W-1:0]    blend_byte;
    logic [COLOR_W-1:0]   shown_masked;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OFF;
            color_a_reg <= '0;
            color_b_reg <= '0;
            period_reg  <= '0;
            btimes_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:    mode_reg    <= cfg_data[1:0];
                CFG_COLOR_A: color_a_reg <= cfg_data[COLOR_W-1:0];
                CFG_COLOR_B: color_b_reg <= cfg_data[COLOR_W-1:0];
                CFG_GRAD:    period_reg  <= TICK_BITS'(cfg_data[GRAD_W-1:0]);
                CFG_BTIMES:  btimes_reg  <= cfg_data[BTIMES_W-1:0];
                default:     ;
            endcase
        end
    end

    // period position arithmetic
    always_comb
    begin
        tp1  = {1'b0, tick_position_reg} + {{TICK_BITS{1'b0}}, 1'b1};
        half = period_reg >> 1;
        if (tick_position_reg < half)
            xdist = tick_position_reg;
        else
            xdist = period_reg - tick_position_reg;
        mix_dividend = {xdist, 8'd0} - DIV_W'(xdist);
        bl_dec       = blink_left_reg - {{(BLEFT_W-1){1'b0}}, 1'b1};
    end

    // shared divider: period wrap, then mix
    assign div_start    = cmd.mod_start | cmd.mix_start;
    assign div_dividend = cmd.mod_start ? DIV_W'(tp1) : mix_dividend;
    assign div_divisor  = cmd.mod_start ? period_reg : half;

    lba_div #(
        .DVD_W (DIV_W),
        .DVS_W (TICK_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // blend one channel: a*255 + (b-a)*mix
    always_comb
    begin
        case (cmd.ch)
            CH_RED:
            begin
                ch_a = color_a_reg[23:16];
                ch_b = color_b_reg[23:16];
            end
            CH_GREEN:
            begin
                ch_a = color_a_reg[15:8];
                ch_b = color_b_reg[15:8];
            end
            default:
            begin
                ch_a = color_a_reg[7:0];
                ch_b = color_b_reg[7:0];
            end
        endcase
        ch_diff = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
        ch_prod = ch_diff * $signed({1'b0, mix_reg});
        ch_base = $signed({2'b00, ch_a, 8'd0}) - $signed({10'd0, ch_a});
        ch_sum  = ch_base + ch_prod;
    end

    // divide by 255: reciprocal estimate plus one correction step
    always_comb
    begin
        recip  = {8'd0, blend_reg} + {blend_reg, 8'd0};
        q_est  = recip[23:16];
        q_back = {q_est, 8'd0} - {8'd0, q_est};
        q_rem  = blend_reg - q_back;
        blend_byte = (q_rem >= 16'(MIX_MAX)) ? q_est + 8'd1 : q_est;
    end

    // next animation state
    always_comb
    begin
        tick_position_next = tick_position_reg;
        blink_left_next    = blink_left_reg;
        shown_color_next   = shown_color_reg;
        shown_lit_next     = shown_lit_reg;
        anim_active_next   = anim_active_reg;

        if (cmd.simple_step)
        begin
            if (restart_reg)
            begin
                case (mode_reg)
                    MODE_OFF:
                    begin
                        anim_active_next   = 1'b0;
                        tick_position_next = '0;
                        shown_lit_next     = 1'b0;
                    end
                    MODE_STEADY:
                    begin
                        anim_active_next   = 1'b0;
                        tick_position_next = '0;
                        shown_color_next   = color_a_reg;
                        shown_lit_next     = 1'b1;
                    end
                    MODE_GRAD:
                    begin
                        tick_position_next = '0;
                        shown_color_next   = color_a_reg;
                        shown_lit_next     = 1'b1;
                        anim_active_next   = 1'b1;
                    end
                    default:
                    begin
                        tick_position_next = '0;
                        blink_left_next    = {btimes_reg, 1'b0};
                        anim_active_next   = 1'b1;
                    end
                endcase
            end
            else if (anim_active_reg)
            begin
                case (mode_reg)
                    MODE_BLINK:
                    begin
                        blink_left_next = bl_dec;
                        if (bl_dec[0])
                        begin
                            shown_color_next = color_a_reg;
                            shown_lit_next   = 1'b1;
                        end
                        else
                        begin
                            shown_lit_next = 1'b0;
                            if (bl_dec == '0 && btimes_reg != '0)
                            begin
                                anim_active_next   = 1'b0;
                                tick_position_next = '0;
                            end
                        end
                    end
                    // gradient with a too-short period holds
                    MODE_GRAD: ;
                    default:
                    begin
                        anim_active_next   = 1'b0;
                        tick_position_next = '0;
                    end
                endcase
            end
        end

        if (cmd.pos_inc)
            tick_position_next = tp1[TICK_BITS-1:0];
        if (cmd.mod_store)
            tick_position_next = div_rem;

        if (cmd.blend_div)
        begin
            case (cmd.ch)
                CH_RED:   shown_color_next[23:16] = blend_byte;
                CH_GREEN: shown_color_next[15:8]  = blend_byte;
                default:  shown_color_next[7:0]   = blend_byte;
            endcase
            shown_lit_next = 1'b1;
        end
    end

    // animation state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_position_reg <= '0;
            blink_left_reg    <= '0;
            shown_color_reg   <= '0;
            shown_lit_reg     <= 1'b0;
            anim_active_reg   <= 1'b0;
        end
        else
        begin
            tick_position_reg <= tick_position_next;
            blink_left_reg    <= blink_left_next;
            shown_color_reg   <= shown_color_next;
            shown_lit_reg     <= shown_lit_next;
            anim_active_reg   <= anim_active_next;
        end
    end

    // work registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            restart_reg <= in_restart;
        if (cmd.mix_store)
            mix_reg <= (|div_quo[DIV_W-1:8]) ? MIX_MAX : div_quo[7:0];
        if (cmd.blend_mul)
            blend_reg <= ch_sum[15:0];
    end

    // result register
    assign shown_masked = shown_lit_reg ? shown_color_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {shown_masked[7:0], shown_masked[15:8], shown_masked[23:16]};
            out_user_reg <= {anim_active_reg, shown_lit_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // status to controller
    always_comb
    begin
        stat.grad_tick = !restart_reg && anim_active_reg && (mode_reg == MODE_GRAD)
                         && (|period_reg[TICK_BITS-1:2]);
        stat.tp1_lt_p  = tp1 < {1'b0, period_reg};
        stat.div_done  = div_done;
        stat.out_free  = !out_valid_reg || m_axis_tready;
    end

endmodule

// ===== rtl/lba_ctrl.sv =====
// lba_ctrl: sequencer of the animator, one request at a time
// depends on lba_pkg; drives lba_datapath through lba_cmd_t
module lba_ctrl
    import lba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  lba_stat_t stat,
    output lba_cmd_t  cmd
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MOD_WAIT,
        ST_MIX_START,
        ST_MIX_WAIT,
        ST_BLEND_MUL,
        ST_BLEND_DIV,
        ST_FINISH
    } state_t;

    state_t     state_reg;
    logic [1:0] ch_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // state and channel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_RED;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (!stat.grad_tick)
                        state_reg <= ST_FINISH;
                    else if (stat.tp1_lt_p)
                        state_reg <= ST_MIX_START;
                    else
                        state_reg <= ST_MOD_WAIT;
                end
                ST_MOD_WAIT:
                begin
                    if (stat.div_done)
                        state_reg <= ST_MIX_START;
                end
                ST_MIX_START:
                    state_reg <= ST_MIX_WAIT;
                ST_MIX_WAIT:
                begin
                    if (stat.div_done)
                    begin
                        ch_reg    <= CH_RED;
                        state_reg <= ST_BLEND_MUL;
                    end
                end
                ST_BLEND_MUL:
                    state_reg <= ST_BLEND_DIV;
                ST_BLEND_DIV:
                begin
                    if (ch_reg == CH_BLUE)
                        state_reg <= ST_FINISH;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_BLEND_MUL;
                    end
                end
                ST_FINISH:
                begin
                    if (stat.out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // command decode
    always_comb
    begin
        cmd    = '0;
        cmd.ch = ch_reg;
        case (state_reg)
            ST_IDLE:      cmd.take_item = s_axis_tvalid;
            ST_DECIDE:
            begin
                cmd.simple_step = !stat.grad_tick;
                cmd.pos_inc     = stat.grad_tick && stat.tp1_lt_p;
                cmd.mod_start   = stat.grad_tick && !stat.tp1_lt_p;
            end
            ST_MOD_WAIT:  cmd.mod_store = stat.div_done;
            ST_MIX_START: cmd.mix_start = 1'b1;
            ST_MIX_WAIT:  cmd.mix_store = stat.div_done;
            ST_BLEND_MUL: cmd.blend_mul = 1'b1;
            ST_BLEND_DIV: cmd.blend_div = 1'b1;
            ST_FINISH:    cmd.out_load  = stat.out_free;
            default:      ;
        endcase
    end

endmodule

// ===== rtl/led_breathe_blink_animator.sv =====
// led_breathe_blink_animator: top level of the RGB LED animator
// depends on lba_pkg, lba_ctrl, lba_datapath (and lba_div below it)
//
// Takes one request at a time: bit 0 of s_axis_tdata set restarts the
// configured mode, clear is one animation tick; each request gives one
// result with the LED color (red in the low byte), lit and running flags.
// Restarts, blink ticks and idle ticks go from acceptance through the
// decide and finish states into the output register. A gradient tick
// also passes the bit-serial divider that forms the triangle mix and
// the one-channel blend unit; when the next tick position reaches or
// passes the period, the wrap goes through the same divider first.
// A new request is taken while the previous result still waits in the
// output register. Configuration writes are always accepted and must only
// be issued while no request is in flight.
module led_breathe_blink_animator
    import lba_pkg::*;
#(
    parameter int TICK_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DAT_W-1:0]  s_axis_tdata,   // [0] restart
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [COLOR_W-1:0]   m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic [OUT_USR_W-1:0] m_axis_tuser,   // [0] lit, [1] running
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);
    lba_cmd_t  cmd;
    lba_stat_t stat;

    // sequencer
    lba_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // registers and arithmetic
    lba_datapath #(
        .TICK_BITS (TICK_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_restart    (s_axis_tdata[0]),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/lba_checker.sv =====
// lba_checker: port-level assertions for the animator
// depends on lba_pkg; bound to led_breathe_blink_animator below
module lba_checker
    import lba_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [COLOR_W-1:0]   m_axis_tdata,
    input logic [OUT_USR_W-1:0] m_axis_tuser
);
    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // a cleared LED shows black
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("color shown on a cleared LED");

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

endmodule

bind led_breathe_blink_animator lba_checker u_lba_checker (.*);

// ===== tb/led_breathe_blink_animator_tb.sv =====
// led_breathe_blink_animator_tb: self-checking bench for the RGB LED animator
// drives restart/tick requests and register writes, predicts every LED frame
// depends on lba_pkg and led_breathe_blink_animator
module led_breathe_blink_animator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lba_pkg::*;

    localparam int TOTAL_REQUESTS = 1750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT = 1100;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 900;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct {
        bit [CHAN_W-1:0] red;
        bit [CHAN_W-1:0] green;
        bit [CHAN_W-1:0] blue;
        bit              lit;
        bit              running;
    } led_frame_t;

    // register copy, animation state and the frames still to come out
    class led_frame_scoreboard;
        bit [1:0]          mode;
        bit [COLOR_W-1:0]  color_a;
        bit [COLOR_W-1:0]  color_b;
        bit [GRAD_W-1:0]   period;
        bit [BTIMES_W-1:0] blink_times;
        bit [GRAD_W-1:0]   tick_pos;
        bit [BLEFT_W-1:0]  blink_left;
        bit [COLOR_W-1:0]  shown_color;
        bit                shown_lit;
        bit                anim_on;
        led_frame_t        expected_frames[$];
        int                errors;

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_MODE:    mode = data[1:0];
                CFG_COLOR_A: color_a = data[COLOR_W-1:0];
                CFG_COLOR_B: color_b = data[COLOR_W-1:0];
                CFG_GRAD:    period = data[GRAD_W-1:0];
                CFG_BTIMES:  blink_times = data[BTIMES_W-1:0];
                default:     ;
            endcase
        endfunction

        function void stop_anim();
            anim_on = 1'b0;
            tick_pos = '0;
        endfunction

        // triangle mix over the period, then per-channel blend of a toward b
        function void gradient_step();
            int unsigned p;
            int unsigned pos;
            int unsigned half;
            int unsigned mix;
            int unsigned a;
            int unsigned b;
            bit [COLOR_W-1:0] blended;
            p = 32'(period);
            if (p < 4)
                return;
            pos = (32'(tick_pos) + 1) % p;
            tick_pos = pos[GRAD_W-1:0];
            half = p / 2;
            if (pos < half)
                mix = pos * 255 / half;
            else
                mix = (p - pos) * 255 / half;
            if (mix > 255)
                mix = 255;
            for (int sh = 0; sh < COLOR_W; sh += CHAN_W)
            begin
                a = 32'(color_a[sh +: CHAN_W]);
                b = 32'(color_b[sh +: CHAN_W]);
                blended[sh +: CHAN_W] = CHAN_W'((a * (255 - mix) + b * mix) / 255);
            end
            shown_color = blended;
            shown_lit = 1'b1;
        endfunction

        // odd count lights color a, even clears; zero ends a counted blink
        function void blink_step();
            blink_left = blink_left - 1'b1;
            if (blink_left[0])
            begin
                shown_color = color_a;
                shown_lit = 1'b1;
            end
            else
            begin
                shown_lit = 1'b0;
                if (blink_left == 0 && blink_times != 0)
                    stop_anim();
            end
        endfunction

        // an accepted request: advance the animation and queue the frame
        function void note_request(bit restart);
            led_frame_t frame;
            bit [COLOR_W-1:0] shown;
            if (restart)
            begin
                case (mode)
                    MODE_OFF:
                    begin
                        stop_anim();
                        shown_lit = 1'b0;
                    end
                    MODE_STEADY:
                    begin
                        stop_anim();
                        shown_color = color_a;
                        shown_lit = 1'b1;
                    end
                    MODE_GRAD:
                    begin
                        tick_pos = '0;
                        shown_color = color_a;
                        shown_lit = 1'b1;
                        anim_on = 1'b1;
                    end
                    default:
                    begin
                        tick_pos = '0;
                        blink_left = {blink_times, 1'b0};
                        anim_on = 1'b1;
                    end
                endcase
            end
            else if (anim_on)
            begin
                if (mode == MODE_GRAD)
                    gradient_step();
                else if (mode == MODE_BLINK)
                    blink_step();
                else
                    stop_anim();
            end
            shown = shown_lit ? shown_color : '0;
            frame.red = shown[23:16];
            frame.green = shown[15:8];
            frame.blue = shown[7:0];
            frame.lit = shown_lit;
            frame.running = anim_on;
            expected_frames.push_back(frame);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // an accepted result against the oldest queued frame
        function void check_result(bit [COLOR_W-1:0] data, bit [OUT_USR_W-1:0] user);
            led_frame_t want;
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, actual data %h user %b",
                         $time, data, user);
                errors++;
                return;
            end
            want = expected_frames.pop_front();
            compare_field("red", 32'(want.red), 32'(data[7:0]));
            compare_field("green", 32'(want.green), 32'(data[15:8]));
            compare_field("blue", 32'(want.blue), 32'(data[23:16]));
            compare_field("lit", 32'(want.lit), 32'(user[0]));
            compare_field("running", 32'(want.running), 32'(user[1]));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DAT_W-1:0]  s_axis_tdata = '0;    // [0] restart
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [COLOR_W-1:0]   m_axis_tdata;         // [7:0] red, [15:8] green, [23:16] blue
    logic [OUT_USR_W-1:0] m_axis_tuser;         // [0] lit, [1] running
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    led_frame_scoreboard sb = new();
    int  requests_sent = 0;
    bit  no_idle = 1'b0;
    bit  hold_off_go = 1'b0;
    bit  held_once = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;

    led_breathe_blink_animator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // handshake monitors feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata[0]);
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
    end

    // result receiver: random stalls, one long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_go && !held_once)
        begin
            held_once = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 20);
    end

    // watchdog on cycles with no handshake at all
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // one request; valid stays high into the next call unless a gap is taken
    task automatic send_request(input bit restart);
        if (!no_idle && $urandom_range(0, 99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_DAT_W - 1){1'b0}}, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
        no_idle = (requests_sent >= CALM_FROM && requests_sent < CALM_TO);
    endtask

    // stop offering and wait for every queued frame, then a short tail
    task automatic settle(input int tail);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_frames.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // register write, only once the block is idle
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        settle(4);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // occasionally set bits above the register width
    function automatic logic [CFG_DAT_W-1:0] with_spare_bits(
        input logic [CFG_DAT_W-1:0] value, input int width);
        logic [CFG_DAT_W-1:0] spare;
        spare = CFG_DAT_W'($urandom);
        if ($urandom_range(0, 3) != 0)
            return value;
        return value | (spare << width);
    endfunction

    function automatic logic [1:0] pick_mode();
        case ($urandom_range(0, 9))
            0:          return MODE_OFF;
            1:          return MODE_STEADY;
            2, 3, 4, 5: return MODE_GRAD;
            default:    return MODE_BLINK;
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // mostly short periods so the triangle turns over within a phase
    function automatic logic [GRAD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return GRAD_W'($urandom_range(0, 3));
            1:       return '1;
            2:       return GRAD_W'($urandom_range(0, 4095));
            default: return GRAD_W'($urandom_range(4, 40));
        endcase
    endfunction

    // mostly short counted blinks, some continuous
    function automatic logic [BTIMES_W-1:0] pick_blink_times();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            3:       return BTIMES_W'($urandom_range(0, 255));
            default: return BTIMES_W'($urandom_range(1, 6));
        endcase
    endfunction

    // new settings (some left as they are), usually a restart, then ticks
    task automatic random_phase();
        int run_len;
        if ($urandom_range(0, 1))
            set_reg(CFG_MODE, with_spare_bits(CFG_DAT_W'(pick_mode()), 2));
        if ($urandom_range(0, 1))
            set_reg(CFG_COLOR_A, pick_color());
        if ($urandom_range(0, 1))
            set_reg(CFG_COLOR_B, pick_color());
        if ($urandom_range(0, 1))
            set_reg(CFG_GRAD, with_spare_bits(CFG_DAT_W'(pick_period()), GRAD_W));
        if ($urandom_range(0, 1))
            set_reg(CFG_BTIMES, with_spare_bits(CFG_DAT_W'(pick_blink_times()), BTIMES_W));
        if ($urandom_range(0, 19) == 0)
            set_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                    CFG_DAT_W'($urandom));
        run_len = $urandom_range(5, 60);
        if (!hold_off_go && requests_sent >= HOLD_OFF_AT)
        begin
            hold_off_go = 1'b1;
            run_len = 40;
        end
        if ($urandom_range(0, 9) < 8)
            send_request(1'b1);
        repeat (run_len) send_request($urandom_range(0, 99) < 3);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick and restart straight after reset
        send_request(1'b0);
        send_request(1'b1);
        // steady white
        set_reg(CFG_MODE, CFG_DAT_W'(MODE_STEADY));
        set_reg(CFG_COLOR_A, '1);
        send_request(1'b1);
        send_request(1'b0);
        // gradient black to white, period too short to move
        set_reg(CFG_MODE, CFG_DAT_W'(MODE_GRAD));
        set_reg(CFG_COLOR_A, '0);
        set_reg(CFG_COLOR_B, '1);
        set_reg(CFG_GRAD, CFG_DAT_W'(3));
        send_request(1'b1);
        send_request(1'b0);
        // odd period, mix saturates at the turn
        set_reg(CFG_GRAD, CFG_DAT_W'(5));
        send_request(1'b1);
        repeat (5) send_request(1'b0);
        // longest period
        set_reg(CFG_GRAD, '1);
        send_request(1'b1);
        send_request(1'b0);
        // single counted blink runs out
        set_reg(CFG_MODE, CFG_DAT_W'(MODE_BLINK));
        set_reg(CFG_BTIMES, CFG_DAT_W'(1));
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        // continuous blink, then cut off by a mode change
        set_reg(CFG_BTIMES, '0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        set_reg(CFG_MODE, CFG_DAT_W'(MODE_OFF));
        send_request(1'b0);
        // writes past the last register go nowhere
        set_reg(CFG_UNUSED_LO, '1);
        set_reg(CFG_UNUSED_HI, '1);
        send_request(1'b1);

        while (requests_sent < TOTAL_REQUESTS)
            random_phase();

        settle(80);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lba_pkg.sv
rtl/lba_div.sv
rtl/lba_datapath.sv
rtl/lba_ctrl.sv
rtl/led_breathe_blink_animator.sv
rtl/lba_checker.sv
tb/led_breathe_blink_animator_tb.sv
